// ===== rtl/imu_relative_orientation_rotator_assert.svh =====
// ----------------------------------------------------------------------------
// imu relative orientation rotator assertion macros
// Concurrent assertion shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMU_RELATIVE_ORIENTATION_ROTATOR_ASSERT_SVH
`define IMU_RELATIVE_ORIENTATION_ROTATOR_ASSERT_SVH

// same-cycle implication
`define IROT_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("irot assertion failed");

// next-cycle implication
`define IROT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("irot assertion failed");

`endif

// ===== rtl/irot_pkg.sv =====
// ----------------------------------------------------------------------------
// irot_pkg
// Shared widths, fixed-point constants and payload types of the rotator.
// ----------------------------------------------------------------------------
package irot_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int QUAT_WIDTH   = 16;

   // internal quaternion component, q1.14
   localparam int Q_W    = 16;
   localparam int QFRAC  = 14;
   localparam int PROD_W = 32;
   localparam int MAT_W  = 32;
   localparam int MFRAC  = 2 * QFRAC;

   typedef logic signed [Q_W-1:0] quat_type;

   localparam quat_type QONE  = Q_W'(16384);
   localparam quat_type QZERO = '0;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0]   quat_w;
      logic signed [QUAT_WIDTH-1:0]   quat_x;
      logic signed [QUAT_WIDTH-1:0]   quat_y;
      logic signed [QUAT_WIDTH-1:0]   quat_z;
      logic signed [SAMPLE_WIDTH-1:0] gyro_x;
      logic signed [SAMPLE_WIDTH-1:0] gyro_y;
      logic signed [SAMPLE_WIDTH-1:0] gyro_z;
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0]   rel_w;
      logic signed [QUAT_WIDTH-1:0]   rel_x;
      logic signed [QUAT_WIDTH-1:0]   rel_y;
      logic signed [QUAT_WIDTH-1:0]   rel_z;
      logic signed [SAMPLE_WIDTH-1:0] rot_gyro_x;
      logic signed [SAMPLE_WIDTH-1:0] rot_gyro_y;
      logic signed [SAMPLE_WIDTH-1:0] rot_gyro_z;
      logic signed [SAMPLE_WIDTH-1:0] rot_accel_x;
      logic signed [SAMPLE_WIDTH-1:0] rot_accel_y;
      logic signed [SAMPLE_WIDTH-1:0] rot_accel_z;
      logic                           is_reference;
   } rsp_payload_type;

   // clamp a raw quaternion component to [-1, +1] in q1.14
   function automatic quat_type clamp_quat(input logic signed [QUAT_WIDTH-1:0] raw);
      logic signed [QUAT_WIDTH+Q_W-1:0] ext;
      logic signed [QUAT_WIDTH+Q_W-1:0] hi;
      logic signed [QUAT_WIDTH+Q_W-1:0] lo;
      quat_type                         res;
      ext = {{Q_W{raw[QUAT_WIDTH-1]}}, raw};
      hi  = (QUAT_WIDTH+Q_W)'(16384);
      lo  = -hi;
      if (ext > hi) begin
         res = QONE;
      end else if (ext < lo) begin
         res = -QONE;
      end else begin
         res = ext[Q_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/irot_hamilton_lane.sv =====
// ----------------------------------------------------------------------------
// irot_hamilton_lane
// One component of the quaternion product: four registered products, then a
// sum rounded to q1.14 and clamped to [-1, +1].
// ----------------------------------------------------------------------------
module irot_hamilton_lane (
   input  logic               clock,
   input  logic               en,
   input  irot_pkg::quat_type a [4],
   input  irot_pkg::quat_type b [4],
   output irot_pkg::quat_type sum_q
);
   import irot_pkg::*;

   localparam int SUM_W = PROD_W + 2;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(2 ** (QFRAC - 1));
   localparam logic signed [SUM_W-1:0] HI   = SUM_W'(16384);
   localparam logic signed [SUM_W-1:0] LO   = -HI;

   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [SUM_W-1:0]  acc;
   logic signed [SUM_W-1:0]  rnd;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= PROD_W'(a[k]) * PROD_W'(b[k]);
         end
      end
   end

   always_comb begin
      acc = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
            + SUM_W'(prod_ff[3]);
      rnd = (acc + HALF) >>> QFRAC;
      if (rnd > HI) begin
         sum_q = QONE;
      end else if (rnd < LO) begin
         sum_q = -QONE;
      end else begin
         sum_q = rnd[Q_W-1:0];
      end
   end

endmodule

// ===== rtl/irot_rotate_lane.sv =====
// ----------------------------------------------------------------------------
// irot_rotate_lane
// One rotated vector component: a matrix row times a vector, three registered
// products, then a sum rounded out of q.28 and saturated to the sample range.
// ----------------------------------------------------------------------------
module irot_rotate_lane (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic signed [irot_pkg::MAT_W-1:0]         m_row [3],
   input  logic signed [irot_pkg::SAMPLE_WIDTH-1:0]  vec [3],
   output logic signed [irot_pkg::SAMPLE_WIDTH-1:0]  rot
);
   import irot_pkg::*;

   localparam int RP_W  = MAT_W + SAMPLE_WIDTH;
   localparam int ACC_W = RP_W + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (MFRAC - 1));
   localparam logic signed [ACC_W-1:0] SMAX =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMIN =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [RP_W-1:0]  prod_ff [3];
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] rnd;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= RP_W'(m_row[c]) * RP_W'(vec[c]);
         end
      end
   end

   always_comb begin
      acc = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2]);
      rnd = (acc + HALF) >>> MFRAC;
      if (rnd > SMAX) begin
         rot = SMAX[SAMPLE_WIDTH-1:0];
      end else if (rnd < SMIN) begin
         rot = SMIN[SAMPLE_WIDTH-1:0];
      end else begin
         rot = rnd[SAMPLE_WIDTH-1:0];
      end
   end

endmodule

// ===== rtl/imu_relative_orientation_rotator.sv =====
// ----------------------------------------------------------------------------
// imu_relative_orientation_rotator
// The first request after reset is kept as the reference orientation and comes
// out with the identity quaternion and its vectors unchanged, flagged by
// is_reference. Every later request gives current times the conjugate of the
// reference, rounded to q1.14, and its rotation matrix turns the gyro and accel
// vectors, saturated to 16 bits. The block is a seven-stage pipeline: input
// register, quaternion product (four lanes, products then sum), matrix
// products, matrix entries, vector rotation (six lanes, products then sum) and
// output register. It takes one request every clock while the output is not
// stalled; each stage holds while the one after it is full and cannot move on,
// so up to seven requests are in flight and new requests are still taken while
// a result waits at the output, as long as an earlier stage is empty.
// ----------------------------------------------------------------------------
`include "imu_relative_orientation_rotator_assert.svh"

module imu_relative_orientation_rotator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  irot_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output irot_pkg::rsp_payload_type rsp_payload
);
   import irot_pkg::*;

   localparam int NSTAGE = 7;

   // product indices of the diff quaternion
   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_XZ = 4;
   localparam int P_YZ = 5;
   localparam int P_WX = 6;
   localparam int P_WY = 7;
   localparam int P_WZ = 8;

   localparam logic signed [MAT_W-1:0] M_ONE = MAT_W'(2 ** MFRAC);

   logic [NSTAGE:1] vld_ff;
   logic [NSTAGE:1] vld_in;
   logic [NSTAGE:0] vld_src;
   logic [NSTAGE:1] rdy;
   logic [NSTAGE:1] isref_ff;
   logic            accept;
   logic            rsp_identity;

   quat_type ref_ff [4];
   logic     ref_valid_ff;
   quat_type nref [4];

   quat_type                       q1_ff [4];
   logic signed [SAMPLE_WIDTH-1:0] vec_ff [1:5][2][3];
   quat_type                       dq_ff [3:7][4];
   quat_type                       ham_b [4][4];
   quat_type                       ham_d [4];
   logic signed [PROD_W-1:0]       dp_ff [9];
   logic signed [MAT_W-1:0]        m_ff [3][3];
   logic signed [SAMPLE_WIDTH-1:0] rot_lane [2][3];
   logic signed [SAMPLE_WIDTH-1:0] rot_ff [2][3];

   // stage handshake, a stage moves on when it is empty or its successor moves
   always_comb begin
      rdy[NSTAGE] = !vld_ff[NSTAGE] || rsp_ready;
      for (int i = NSTAGE - 1; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_src = {vld_ff, req_valid};
      vld_in  = vld_ff;
      for (int i = 1; i <= NSTAGE; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_src[i-1];
         end
      end
   end

   assign req_ready = rdy[1];
   assign rsp_valid = vld_ff[NSTAGE];
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ref_valid_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (accept) begin
            ref_valid_ff <= 1'b1;
         end
      end
   end

   // input stage and reference capture
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         q1_ff[0]    <= clamp_quat(req_payload.quat_w);
         q1_ff[1]    <= clamp_quat(req_payload.quat_x);
         q1_ff[2]    <= clamp_quat(req_payload.quat_y);
         q1_ff[3]    <= clamp_quat(req_payload.quat_z);
         vec_ff[1][0][0] <= req_payload.gyro_x;
         vec_ff[1][0][1] <= req_payload.gyro_y;
         vec_ff[1][0][2] <= req_payload.gyro_z;
         vec_ff[1][1][0] <= req_payload.accel_x;
         vec_ff[1][1][1] <= req_payload.accel_y;
         vec_ff[1][1][2] <= req_payload.accel_z;
         isref_ff[1] <= !ref_valid_ff;
      end
      if (accept && !ref_valid_ff) begin
         ref_ff[0] <= clamp_quat(req_payload.quat_w);
         ref_ff[1] <= clamp_quat(req_payload.quat_x);
         ref_ff[2] <= clamp_quat(req_payload.quat_y);
         ref_ff[3] <= clamp_quat(req_payload.quat_z);
      end
      // side-band pipeline of vectors, diff quaternion and reference flag
      for (int s = 2; s <= 5; s++) begin
         if (rdy[s]) begin
            vec_ff[s] <= vec_ff[s-1];
         end
      end
      for (int s = 2; s <= NSTAGE; s++) begin
         if (rdy[s]) begin
            isref_ff[s] <= isref_ff[s-1];
         end
      end
      for (int s = 4; s <= NSTAGE; s++) begin
         if (rdy[s]) begin
            dq_ff[s] <= dq_ff[s-1];
         end
      end
      if (rdy[3]) begin
         if (isref_ff[2]) begin
            dq_ff[3] <= '{QONE, QZERO, QZERO, QZERO};
         end else begin
            dq_ff[3] <= ham_d;
         end
      end
   end

   // current times conjugate of reference, signs folded into the operands
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         nref[k] = -ref_ff[k];
      end
      ham_b[0] = '{ref_ff[0], ref_ff[1], ref_ff[2], ref_ff[3]};
      ham_b[1] = '{nref[1],   ref_ff[0], nref[3],   ref_ff[2]};
      ham_b[2] = '{nref[2],   ref_ff[3], ref_ff[0], nref[1]};
      ham_b[3] = '{nref[3],   nref[2],   ref_ff[1], ref_ff[0]};
   end

   for (genvar gl = 0; gl < 4; gl++) begin : g_ham
      irot_hamilton_lane u_lane (
         .clock (clock),
         .en    (rdy[2]),
         .a     (q1_ff),
         .b     (ham_b[gl]),
         .sum_q (ham_d[gl])
      );
   end

   // products of the diff components
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         dp_ff[P_XX] <= PROD_W'(dq_ff[3][1]) * PROD_W'(dq_ff[3][1]);
         dp_ff[P_YY] <= PROD_W'(dq_ff[3][2]) * PROD_W'(dq_ff[3][2]);
         dp_ff[P_ZZ] <= PROD_W'(dq_ff[3][3]) * PROD_W'(dq_ff[3][3]);
         dp_ff[P_XY] <= PROD_W'(dq_ff[3][1]) * PROD_W'(dq_ff[3][2]);
         dp_ff[P_XZ] <= PROD_W'(dq_ff[3][1]) * PROD_W'(dq_ff[3][3]);
         dp_ff[P_YZ] <= PROD_W'(dq_ff[3][2]) * PROD_W'(dq_ff[3][3]);
         dp_ff[P_WX] <= PROD_W'(dq_ff[3][0]) * PROD_W'(dq_ff[3][1]);
         dp_ff[P_WY] <= PROD_W'(dq_ff[3][0]) * PROD_W'(dq_ff[3][2]);
         dp_ff[P_WZ] <= PROD_W'(dq_ff[3][0]) * PROD_W'(dq_ff[3][3]);
      end
   end

   // rotation matrix in q.28
   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         m_ff[0][0] <= M_ONE - (MAT_W'(dp_ff[P_YY] + dp_ff[P_ZZ]) <<< 1);
         m_ff[0][1] <= MAT_W'(dp_ff[P_XY] - dp_ff[P_WZ]) <<< 1;
         m_ff[0][2] <= MAT_W'(dp_ff[P_XZ] + dp_ff[P_WY]) <<< 1;
         m_ff[1][0] <= MAT_W'(dp_ff[P_XY] + dp_ff[P_WZ]) <<< 1;
         m_ff[1][1] <= M_ONE - (MAT_W'(dp_ff[P_XX] + dp_ff[P_ZZ]) <<< 1);
         m_ff[1][2] <= MAT_W'(dp_ff[P_YZ] - dp_ff[P_WX]) <<< 1;
         m_ff[2][0] <= MAT_W'(dp_ff[P_XZ] - dp_ff[P_WY]) <<< 1;
         m_ff[2][1] <= MAT_W'(dp_ff[P_YZ] + dp_ff[P_WX]) <<< 1;
         m_ff[2][2] <= M_ONE - (MAT_W'(dp_ff[P_XX] + dp_ff[P_YY]) <<< 1);
      end
   end

   for (genvar gv = 0; gv < 2; gv++) begin : g_vec
      for (genvar gr = 0; gr < 3; gr++) begin : g_row
         irot_rotate_lane u_lane (
            .clock (clock),
            .en    (rdy[6]),
            .m_row (m_ff[gr]),
            .vec   (vec_ff[5][gv]),
            .rot   (rot_lane[gv][gr])
         );
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rdy[NSTAGE]) begin
         rot_ff <= rot_lane;
      end
   end

   always_comb begin
      rsp_payload.rel_w        = QUAT_WIDTH'(dq_ff[NSTAGE][0]);
      rsp_payload.rel_x        = QUAT_WIDTH'(dq_ff[NSTAGE][1]);
      rsp_payload.rel_y        = QUAT_WIDTH'(dq_ff[NSTAGE][2]);
      rsp_payload.rel_z        = QUAT_WIDTH'(dq_ff[NSTAGE][3]);
      rsp_payload.rot_gyro_x   = rot_ff[0][0];
      rsp_payload.rot_gyro_y   = rot_ff[0][1];
      rsp_payload.rot_gyro_z   = rot_ff[0][2];
      rsp_payload.rot_accel_x  = rot_ff[1][0];
      rsp_payload.rot_accel_y  = rot_ff[1][1];
      rsp_payload.rot_accel_z  = rot_ff[1][2];
      rsp_payload.is_reference = isref_ff[NSTAGE];
   end

   assign rsp_identity = rsp_payload.rel_w == QONE && rsp_payload.rel_x == QZERO
                         && rsp_payload.rel_y == QZERO && rsp_payload.rel_z == QZERO;

   `IROT_ASSERT_NEXT(a_ref_sticky, ref_valid_ff, ref_valid_ff)
   `IROT_ASSERT_NEXT(a_ref_capture, accept && !ref_valid_ff, vld_ff[1] && isref_ff[1])
   `IROT_ASSERT_IMPLY(a_ref_identity, rsp_valid && rsp_payload.is_reference, rsp_identity)
   `IROT_ASSERT_IMPLY(a_ready_when_drained, !vld_ff[NSTAGE], req_ready)

endmodule

// ===== verif/imu_relative_orientation_rotator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_relative_orientation_rotator_tb
// Self-checking bench for the relative orientation rotator. A directed table
// covers the reference capture, the identity cases, clamping of out-of-range
// components, axis rotations and saturation. A random stream of mostly unit
// quaternions follows, with noise and boundary values mixed in. Each result is
// checked field by field against a bit-exact fixed-point model of the block or
// the pinned result of its table row, with random idling on both channels.
// ----------------------------------------------------------------------------
module imu_relative_orientation_rotator_tb;
   import irot_pkg::*;

   localparam realtime CLK_PERIOD  = 12.0;
   localparam int      RANDOM_REQS = 800;
   localparam int      DRAIN_LIMIT = 20000;
   localparam longint  UNIT        = 64'sd1 <<< QFRAC;
   localparam longint  SMAX        = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint  SMIN        = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

   typedef struct {
      req_payload_type req;
      bit              pinned;
      rsp_payload_type rsp;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // model state
   longint          ref_orient [4];
   bit              ref_captured = 1'b0;

   rsp_payload_type pending_rotations [$];
   stim_row_type    stim_table [$];
   bit              pin_now = 1'b0;
   rsp_payload_type pin_rsp = '0;
   bit              steady = 1'b0;
   bit              draining = 1'b0;
   int              fails = 0;
   int              sent = 0;
   int              checked = 0;
   int              saturated = 0;

   imu_relative_orientation_rotator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(CLK_PERIOD * 400000);
      $display("[imu_relative_orientation_rotator] ERROR");
      $finish;
   end

   function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // round half up, arithmetic shift gives the floor
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic rsp_payload_type rotate_sample(input req_payload_type p);
      longint          q [4];
      longint          d [4];
      longint          v [6];
      longint          s [4];
      longint          m [3][3];
      longint          rot [6];
      longint          bw, bx, by, bz, w, x, y, z, acc;
      rsp_payload_type r;
      q[0] = clamp_l(longint'($signed(p.quat_w)), -UNIT, UNIT);
      q[1] = clamp_l(longint'($signed(p.quat_x)), -UNIT, UNIT);
      q[2] = clamp_l(longint'($signed(p.quat_y)), -UNIT, UNIT);
      q[3] = clamp_l(longint'($signed(p.quat_z)), -UNIT, UNIT);
      v[0] = longint'($signed(p.gyro_x));
      v[1] = longint'($signed(p.gyro_y));
      v[2] = longint'($signed(p.gyro_z));
      v[3] = longint'($signed(p.accel_x));
      v[4] = longint'($signed(p.accel_y));
      v[5] = longint'($signed(p.accel_z));
      r = '0;
      if (!ref_captured) begin
         for (int i = 0; i < 4; i++) ref_orient[i] = q[i];
         ref_captured   = 1'b1;
         r.is_reference = 1'b1;
         d[0] = UNIT; d[1] = 0; d[2] = 0; d[3] = 0;
      end else begin
         bw = ref_orient[0];
         bx = -ref_orient[1];
         by = -ref_orient[2];
         bz = -ref_orient[3];
         s[0] = q[0] * bw - q[1] * bx - q[2] * by - q[3] * bz;
         s[1] = q[0] * bx + q[1] * bw + q[2] * bz - q[3] * by;
         s[2] = q[0] * by - q[1] * bz + q[2] * bw + q[3] * bx;
         s[3] = q[0] * bz + q[1] * by - q[2] * bx + q[3] * bw;
         for (int i = 0; i < 4; i++) d[i] = clamp_l(round_shift(s[i], QFRAC), -UNIT, UNIT);
      end
      w = d[0]; x = d[1]; y = d[2]; z = d[3];
      m[0][0] = UNIT * UNIT - 2 * (y * y + z * z);
      m[0][1] = 2 * (x * y - w * z);
      m[0][2] = 2 * (x * z + w * y);
      m[1][0] = 2 * (x * y + w * z);
      m[1][1] = UNIT * UNIT - 2 * (x * x + z * z);
      m[1][2] = 2 * (y * z - w * x);
      m[2][0] = 2 * (x * z - w * y);
      m[2][1] = 2 * (y * z + w * x);
      m[2][2] = UNIT * UNIT - 2 * (x * x + y * y);
      for (int i = 0; i < 2; i++) begin
         for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int col = 0; col < 3; col++) acc += m[row][col] * v[3 * i + col];
            rot[3 * i + row] = clamp_l(round_shift(acc, MFRAC), SMIN, SMAX);
         end
      end
      r.rel_w       = QUAT_WIDTH'(d[0]);
      r.rel_x       = QUAT_WIDTH'(d[1]);
      r.rel_y       = QUAT_WIDTH'(d[2]);
      r.rel_z       = QUAT_WIDTH'(d[3]);
      r.rot_gyro_x  = SAMPLE_WIDTH'(rot[0]);
      r.rot_gyro_y  = SAMPLE_WIDTH'(rot[1]);
      r.rot_gyro_z  = SAMPLE_WIDTH'(rot[2]);
      r.rot_accel_x = SAMPLE_WIDTH'(rot[3]);
      r.rot_accel_y = SAMPLE_WIDTH'(rot[4]);
      r.rot_accel_z = SAMPLE_WIDTH'(rot[5]);
      return r;
   endfunction

   function automatic req_payload_type mk_req(input int w, x, y, z, gx, gy, gz, ax, ay, az);
      req_payload_type p;
      p.quat_w  = QUAT_WIDTH'(w);
      p.quat_x  = QUAT_WIDTH'(x);
      p.quat_y  = QUAT_WIDTH'(y);
      p.quat_z  = QUAT_WIDTH'(z);
      p.gyro_x  = SAMPLE_WIDTH'(gx);
      p.gyro_y  = SAMPLE_WIDTH'(gy);
      p.gyro_z  = SAMPLE_WIDTH'(gz);
      p.accel_x = SAMPLE_WIDTH'(ax);
      p.accel_y = SAMPLE_WIDTH'(ay);
      p.accel_z = SAMPLE_WIDTH'(az);
      return p;
   endfunction

   // a row whose result is a fixed quaternion with the vectors passed through
   task automatic add_row(input req_payload_type p, input bit pinned,
                          input int w = 0, x = 0, y = 0, z = 0, input bit is_ref = 1'b0);
      stim_row_type row;
      row.req    = p;
      row.pinned = pinned;
      row.rsp    = '{rel_w: QUAT_WIDTH'(w), rel_x: QUAT_WIDTH'(x),
                     rel_y: QUAT_WIDTH'(y), rel_z: QUAT_WIDTH'(z),
                     rot_gyro_x: p.gyro_x, rot_gyro_y: p.gyro_y, rot_gyro_z: p.gyro_z,
                     rot_accel_x: p.accel_x, rot_accel_y: p.accel_y,
                     rot_accel_z: p.accel_z, is_reference: is_ref};
      stim_table.push_back(row);
   endtask

   function automatic int corner_quat();
      int corners [9] = '{-32768, -16385, -16384, -1, 0, 1, 16384, 16385, 32767};
      return corners[$urandom_range(0, 8)];
   endfunction

   function automatic int pick_sample();
      int corners [4] = '{-32768, -1, 0, 32767};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
      return int'($signed(16'($urandom)));
   endfunction

   function automatic req_payload_type random_req();
      req_payload_type p;
      real             a [4];
      real             norm;
      int              c [4];
      int              kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         do begin
            norm = 0.0;
            for (int i = 0; i < 4; i++) begin
               a[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
               norm += a[i] * a[i];
            end
         end while (norm < 0.01);
         norm = $sqrt(norm);
         for (int i = 0; i < 4; i++)
            c[i] = $rtoi(a[i] / norm * 16384.0 + ((a[i] >= 0.0) ? 0.5 : -0.5));
      end else if (kind < 80) begin
         for (int i = 0; i < 4; i++) c[i] = $urandom_range(0, 32768) - 16384;
      end else if (kind < 90) begin
         for (int i = 0; i < 4; i++) c[i] = int'($signed(16'($urandom)));
      end else begin
         for (int i = 0; i < 4; i++) c[i] = corner_quat();
      end
      p = mk_req(c[0], c[1], c[2], c[3], pick_sample(), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), pick_sample());
      return p;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_payload_type p, input bit pinned,
                               input rsp_payload_type pr);
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      pin_now      = pinned;
      pin_rsp      = pr;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fails++;
      end
   endtask

   task automatic compare_rotation(input rsp_payload_type e, input rsp_payload_type a);
      check_field("rel_w", $signed(e.rel_w), $signed(a.rel_w));
      check_field("rel_x", $signed(e.rel_x), $signed(a.rel_x));
      check_field("rel_y", $signed(e.rel_y), $signed(a.rel_y));
      check_field("rel_z", $signed(e.rel_z), $signed(a.rel_z));
      check_field("rot_gyro_x", $signed(e.rot_gyro_x), $signed(a.rot_gyro_x));
      check_field("rot_gyro_y", $signed(e.rot_gyro_y), $signed(a.rot_gyro_y));
      check_field("rot_gyro_z", $signed(e.rot_gyro_z), $signed(a.rot_gyro_z));
      check_field("rot_accel_x", $signed(e.rot_accel_x), $signed(a.rot_accel_x));
      check_field("rot_accel_y", $signed(e.rot_accel_y), $signed(a.rot_accel_y));
      check_field("rot_accel_z", $signed(e.rot_accel_z), $signed(a.rot_accel_z));
      check_field("is_reference", e.is_reference, a.is_reference);
   endtask

   always @(negedge clock) begin
      rsp_ready <= draining || steady || ($urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      rsp_payload_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            exp_rsp = rotate_sample(req_payload);
            if (pin_now) exp_rsp = pin_rsp;
            pending_rotations.push_back(exp_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rotations.size() == 0) begin
               $error("unexpected result, rel_w %0d", $signed(rsp_payload.rel_w));
               fails++;
            end else begin
               exp_rsp = pending_rotations.pop_front();
               got     = rsp_payload;
               compare_rotation(exp_rsp, got);
               checked++;
               if (got.rot_gyro_x == 16'h7fff || got.rot_gyro_x == 16'h8000 ||
                   got.rot_accel_z == 16'h7fff || got.rot_accel_z == 16'h8000)
                  saturated++;
            end
         end
      end
   end

   initial begin
      localparam int R = 8192;
      int n;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reference capture and identity cases
      add_row(mk_req(R, R, R, R, 32767, -32768, 0, -1, 1, 12345), 1, 16384, 0, 0, 0, 1);
      add_row(mk_req(R, R, R, R, -32768, 32767, -32768, 32767, 32767, 32767),
              1, 16384, 0, 0, 0);
      add_row(mk_req(0, 0, 0, 0, -32768, -32768, -32768, 32767, -32768, 32767), 1, 0, 0, 0, 0);
      add_row(mk_req(-R, -R, -R, -R, 100, -200, 300, -400, 500, -600), 1, -16384, 0, 0, 0);
      // out-of-range components clamp to one
      add_row(mk_req(32767, 32767, 32767, 32767, 1, 2, 3, -4, -5, -6), 1, 16384, 0, 0, 0);
      add_row(mk_req(-32768, -32768, -32768, -32768, 7, -8, 9, 10, -11, 12),
              1, -16384, 0, 0, 0);
      // axis rotations, non-unit and saturating cases
      add_row(mk_req(16384, 0, 0, 0, 1000, 2000, 3000, -1000, -2000, -3000), 0);
      add_row(mk_req(11585, 11585, 0, 0, 32767, 0, 0, 0, 0, -32768), 0);
      add_row(mk_req(11585, 0, 11585, 0, 0, 32767, 0, -32768, 0, 0), 0);
      add_row(mk_req(11585, 0, 0, 11585, 0, 0, 32767, 0, -32768, 0), 0);
      add_row(mk_req(0, 16384, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768), 0);
      add_row(mk_req(0, 0, 16384, 0, -32768, -32768, 32767, 32767, 32767, -32768), 0);
      add_row(mk_req(0, 0, 0, 16384, 32767, 32767, 32767, -32768, -32768, -32768), 0);
      add_row(mk_req(16384, 16384, 16384, 16384, 32767, 32767, 32767, 32767, 32767, 32767), 0);
      add_row(mk_req(16384, -16384, 16384, -16384, -32768, -32768, -32768, -32768, -32768,
                     -32768), 0);
      add_row(mk_req(16385, -16385, 0, 0, 12345, -12345, 777, -777, 1, -1), 0);
      add_row(mk_req(-16384, 16384, -16384, 16384, 20000, -20000, 30000, -30000, 5, -5), 0);
      add_row(mk_req(32767, -32768, 1, -1, -1, 0, 1, 32767, -32768, 0), 0);
      add_row(mk_req(R, -R, R, -R, 12345, -12345, 23456, -23456, 3456, -3456), 0);
      add_row(mk_req(-1, 1, -1, 1, 32767, -32768, -1, 0, 1, 2), 0);

      foreach (stim_table[i])
         send_request(stim_table[i].req, stim_table[i].pinned, stim_table[i].rsp);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         steady = (i >= 300 && i < 450);
         send_request(random_req(), 1'b0, '0);
      end
      steady    = 1'b0;
      req_valid <= 1'b0;
      draining  = 1'b1;

      n = 0;
      while (pending_rotations.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_rotations.size() != 0) begin
         $error("%0d results never arrived", pending_rotations.size());
         fails++;
      end
      repeat (16) @(posedge clock);

      $display("requests sent: %0d (%0d directed), results checked: %0d, saturated: %0d",
               sent, stim_table.size(), checked, saturated);
      $display("failures: %0d", fails);
      if (fails == 0) begin
         $display("[imu_relative_orientation_rotator] OK");
      end else begin
         $display("[imu_relative_orientation_rotator] ERROR");
      end
      $finish;
   end

endmodule
